// ===== design/srp_pkg.sv =====
package srp_pkg;

   localparam int BYTE_W      = 8;
   localparam int VALUE_W     = 41;
   localparam int STREAK_W    = 8;
   localparam int CSR_INDEX_W = 8;

   localparam logic [BYTE_W-1:0] CHAR_PLUS   = 8'h2B;
   localparam logic [BYTE_W-1:0] CHAR_MINUS  = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_PERIOD = 8'h2E;
   localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;

   localparam logic [CSR_INDEX_W-1:0] CSR_SEPARATOR    = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STABLE_COUNT = 8'd1;

   localparam logic [BYTE_W-1:0]   SEPARATOR_RESET    = CHAR_PERIOD;
   localparam logic [STREAK_W-1:0] STABLE_COUNT_RESET = 8'd1;
   localparam logic [STREAK_W-1:0] STREAK_MAX         = 8'hFF;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One classified byte as it travels from the front end to the scanner.
   typedef struct packed {
      logic       is_digit;
      logic       is_sep;
      logic       is_sign;
      logic       is_minus;
      logic       eol;
      logic [3:0] digit;
   } byte_class_type;

   // Line summary flags handed from the scanner to the result stage.
   typedef struct packed {
      logic found;
      logic overflow;
      logic minus;
   } line_flags_type;

   function automatic logic [63:0] pow10(input logic [4:0] n);
      logic [63:0] p;
      case (n)
         5'd0:    p = 64'd1;
         5'd1:    p = 64'd10;
         5'd2:    p = 64'd100;
         5'd3:    p = 64'd1000;
         5'd4:    p = 64'd10000;
         5'd5:    p = 64'd100000;
         5'd6:    p = 64'd1000000;
         5'd7:    p = 64'd10000000;
         5'd8:    p = 64'd100000000;
         5'd9:    p = 64'd1000000000;
         5'd10:   p = 64'd10000000000;
         5'd11:   p = 64'd100000000000;
         5'd12:   p = 64'd1000000000000;
         5'd13:   p = 64'd10000000000000;
         5'd14:   p = 64'd100000000000000;
         5'd15:   p = 64'd1000000000000000;
         5'd16:   p = 64'd10000000000000000;
         5'd17:   p = 64'd100000000000000000;
         default: p = 64'd1000000000000000000;
      endcase
      return p;
   endfunction

endpackage

// ===== design/srp_front.sv =====
module srp_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [srp_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic                         req_end_of_line,
   input  logic [srp_pkg::BYTE_W-1:0]   separator,
   output logic                         q_valid,
   output srp_pkg::byte_class_type      q_entry,
   input  logic                         q_pop
);

   srp_pkg::byte_class_type entry_ff [srp_pkg::QUEUE_DEPTH];
   srp_pkg::byte_class_type cls;
   logic [srp_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [srp_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [srp_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic [srp_pkg::BYTE_W-1:0]      offset;
   logic                            push;

   // A digit byte always wins over the separator, and the separator over a sign.
   always_comb begin
      offset       = req_data_byte - srp_pkg::CHAR_ZERO;
      cls.is_digit = (req_data_byte >= srp_pkg::CHAR_ZERO) &&
                     (req_data_byte <= srp_pkg::CHAR_NINE);
      cls.is_sep   = !cls.is_digit && (req_data_byte == separator);
      cls.is_sign  = !cls.is_digit && !cls.is_sep &&
                     ((req_data_byte == srp_pkg::CHAR_PLUS) ||
                      (req_data_byte == srp_pkg::CHAR_MINUS));
      cls.is_minus = (req_data_byte == srp_pkg::CHAR_MINUS);
      cls.eol      = req_end_of_line;
      cls.digit    = offset[3:0];
   end

   assign req_ready = (count_ff != srp_pkg::QUEUE_CNT_W'(srp_pkg::QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_entry   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == srp_pkg::QUEUE_PTR_W'(srp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == srp_pkg::QUEUE_PTR_W'(srp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ===== design/srp_scan.sv =====
module srp_scan #(
   parameter int TOKEN_MAX       = 31,
   parameter int FRACTION_DIGITS = 6,
   parameter int INTEGER_DIGITS  = 6,
   parameter int MAG_W           = 40
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  srp_pkg::byte_class_type  q_entry,
   output logic                     q_pop,
   output logic                     sum_valid,
   output srp_pkg::line_flags_type  sum_flags,
   output logic [MAG_W-1:0]         sum_mag,
   input  logic                     sum_take
);

   localparam int LEN_W = $clog2(TOKEN_MAX + 1);
   localparam int FDS_W = $clog2(FRACTION_DIGITS + 1);
   localparam int SUM_W = MAG_W + 4;
   localparam logic [63:0] MAG_MAX64 =
      srp_pkg::pow10(5'(INTEGER_DIGITS + FRACTION_DIGITS)) - 64'd1;
   localparam logic [63:0] INT_SCALE64 = srp_pkg::pow10(5'(FRACTION_DIGITS));
   localparam logic [MAG_W-1:0] MAG_MAX   = MAG_MAX64[MAG_W-1:0];
   localparam logic [SUM_W-1:0] MAG_MAX_S = SUM_W'(MAG_MAX64);
   localparam logic [SUM_W-1:0] INT_SCALE = SUM_W'(INT_SCALE64);

   typedef enum logic [1:0] {
      PH_SEARCH,
      PH_TOKEN,
      PH_DONE
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic       dig_ff, dig_in;
   logic       sep_ff, sep_in;
   logic [FDS_W-1:0] fds_ff, fds_in;
   logic [MAG_W-1:0] mag_ff, mag_in;
   logic       sat_ff, sat_in;
   logic       minus_ff, minus_in;
   logic       sum_valid_ff, sum_valid_in;
   srp_pkg::line_flags_type sum_flags_ff, sum_flags_in;
   logic [MAG_W-1:0] sum_mag_ff, sum_mag_in;

   srp_pkg::byte_class_type e;
   logic             is_num, cur_ok, use_cur;
   logic [LEN_W-1:0] b_len, x_len;
   logic             b_dig, b_sep, b_sat, x_dig, x_sep, x_sat;
   logic [FDS_W-1:0] b_fds, x_fds;
   logic [MAG_W-1:0] b_mag, x_mag, frac_sum;
   logic [SUM_W-1:0] int_sum;
   logic [4:0]       frac_exp;

   // A byte that closes the summary waits until the result stage has room.
   assign q_pop = q_valid && (!q_entry.eol || !sum_valid_ff || sum_take);

   always_comb begin
      e       = q_entry;
      is_num  = e.is_digit || e.is_sep || e.is_sign;
      cur_ok  = e.is_digit || (e.is_sep && !sep_ff) || (e.is_sign && (len_ff == '0));
      use_cur = (phase_ff == PH_TOKEN) && cur_ok;

      // A byte that cannot extend the open token, or that opens one, starts from
      // an empty token.
      if (use_cur) begin
         b_len = len_ff;
         b_dig = dig_ff;
         b_sep = sep_ff;
         b_fds = fds_ff;
         b_mag = mag_ff;
         b_sat = sat_ff;
      end else begin
         b_len = '0;
         b_dig = 1'b0;
         b_sep = 1'b0;
         b_fds = '0;
         b_mag = '0;
         b_sat = 1'b0;
      end

      int_sum  = ({4'b0000, b_mag} << 3) + ({4'b0000, b_mag} << 1) +
                 SUM_W'(e.digit) * INT_SCALE;
      frac_exp = 5'(FRACTION_DIGITS - 1) - 5'(b_fds);
      frac_sum = b_mag + MAG_W'(e.digit) * MAG_W'(srp_pkg::pow10(frac_exp));

      x_len = b_len + 1'b1;
      x_dig = b_dig || e.is_digit;
      x_sep = b_sep || e.is_sep;
      x_fds = b_fds;
      x_mag = b_mag;
      x_sat = b_sat;
      if (e.is_digit && !b_sat) begin
         if (!b_sep) begin
            if (int_sum > MAG_MAX_S) begin
               x_mag = MAG_MAX;
               x_sat = 1'b1;
            end else begin
               x_mag = int_sum[MAG_W-1:0];
            end
         end else if (b_fds < FDS_W'(FRACTION_DIGITS)) begin
            x_mag = frac_sum;
            x_fds = b_fds + 1'b1;
         end
      end

      phase_in     = phase_ff;
      len_in       = len_ff;
      dig_in       = dig_ff;
      sep_in       = sep_ff;
      fds_in       = fds_ff;
      mag_in       = mag_ff;
      sat_in       = sat_ff;
      minus_in     = minus_ff;
      sum_valid_in = sum_valid_ff && !sum_take;
      sum_flags_in = sum_flags_ff;
      sum_mag_in   = sum_mag_ff;

      if (q_pop) begin
         minus_in = minus_ff || e.is_minus;
         if (phase_ff != PH_DONE) begin
            if ((phase_ff == PH_TOKEN) && !cur_ok && dig_ff) begin
               phase_in = PH_DONE;
            end else if (use_cur || is_num) begin
               phase_in = PH_TOKEN;
               len_in   = x_len;
               dig_in   = x_dig;
               sep_in   = x_sep;
               fds_in   = x_fds;
               mag_in   = x_mag;
               sat_in   = x_sat;
               if (x_len >= LEN_W'(TOKEN_MAX)) begin
                  if (x_dig) begin
                     phase_in = PH_DONE;
                  end else if (x_len == LEN_W'(2)) begin
                     // A sign and a separator filled the token: keep the separator.
                     len_in = LEN_W'(1);
                     sep_in = 1'b1;
                  end else begin
                     phase_in = PH_SEARCH;
                  end
               end
            end else begin
               phase_in = PH_SEARCH;
            end
         end
         if (e.eol) begin
            sum_flags_in.found    = (phase_in == PH_DONE) ||
                                    ((phase_in == PH_TOKEN) && dig_in);
            sum_flags_in.overflow = sum_flags_in.found && sat_in;
            sum_flags_in.minus    = minus_in;
            sum_mag_in            = mag_in;
            sum_valid_in          = 1'b1;
            phase_in              = PH_SEARCH;
            minus_in              = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SEARCH;
         minus_ff     <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         minus_ff     <= minus_in;
         sum_valid_ff <= sum_valid_in;
      end
      len_ff       <= len_in;
      dig_ff       <= dig_in;
      sep_ff       <= sep_in;
      fds_ff       <= fds_in;
      mag_ff       <= mag_in;
      sat_ff       <= sat_in;
      sum_flags_ff <= sum_flags_in;
      sum_mag_ff   <= sum_mag_in;
   end

   assign sum_valid = sum_valid_ff;
   assign sum_flags = sum_flags_ff;
   assign sum_mag   = sum_mag_ff;

endmodule

// ===== design/srp_result.sv =====
module srp_result #(
   parameter int MAG_W = 40
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                sum_valid,
   input  srp_pkg::line_flags_type             sum_flags,
   input  logic [MAG_W-1:0]                    sum_mag,
   output logic                                sum_take,
   input  logic [srp_pkg::STREAK_W-1:0]        stable_count,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic signed [srp_pkg::VALUE_W-1:0]  rsp_value_scaled,
   output logic                                rsp_overflow,
   output logic                                rsp_stable,
   output logic [srp_pkg::STREAK_W-1:0]        rsp_streak_length
);

   logic [srp_pkg::VALUE_W-1:0]  held_ff, held_in;
   logic [srp_pkg::STREAK_W-1:0] streak_ff, streak_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         found_ff, found_in;
   logic [srp_pkg::VALUE_W-1:0]  value_ff, value_in;
   logic                         overflow_ff, overflow_in;
   logic                         stable_ff, stable_in;
   logic [srp_pkg::STREAK_W-1:0] length_ff, length_in;

   logic [srp_pkg::VALUE_W-1:0]  mag_v, value;
   logic [srp_pkg::STREAK_W-1:0] streak_new;
   logic                         stable;

   assign sum_take = sum_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      mag_v = srp_pkg::VALUE_W'(sum_mag);
      value = sum_flags.minus ? (~mag_v + 1'b1) : mag_v;
      if ((streak_ff == '0) || (value == held_ff)) begin
         streak_new = (streak_ff == srp_pkg::STREAK_MAX) ? streak_ff : streak_ff + 1'b1;
      end else begin
         streak_new = srp_pkg::STREAK_W'(1);
      end
      stable = (streak_new >= stable_count);

      held_in      = held_ff;
      streak_in    = streak_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      found_in     = found_ff;
      value_in     = value_ff;
      overflow_in  = overflow_ff;
      stable_in    = stable_ff;
      length_in    = length_ff;

      if (sum_take) begin
         rsp_valid_in = 1'b1;
         found_in     = sum_flags.found;
         overflow_in  = sum_flags.overflow;
         if (sum_flags.found) begin
            held_in   = value;
            streak_in = stable ? '0 : streak_new;
            value_in  = value;
            stable_in = stable;
            length_in = streak_new;
         end else begin
            // A line with no number breaks the streak.
            streak_in = '0;
            value_in  = '0;
            stable_in = 1'b0;
            length_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         streak_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         streak_ff    <= streak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      found_ff    <= found_in;
      value_ff    <= value_in;
      overflow_ff <= overflow_in;
      stable_ff   <= stable_in;
      length_ff   <= length_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = found_ff;
   assign rsp_value_scaled  = value_ff;
   assign rsp_overflow      = overflow_ff;
   assign rsp_stable        = stable_ff;
   assign rsp_streak_length = length_ff;

endmodule

// ===== design/scale_reading_parser_with_stability_unit.sv =====
// Scale reply parser: bytes of one reply line enter one per clock on the req
// channel, and the byte flagged end_of_line yields one response holding the first
// number of the line, scaled by 10^FRACTION_DIGITS, with overflow, stability and
// streak information. The sustained rate is one request per clock while responses
// are taken; it is set by the scanner, which folds each byte into the token state
// (one times-ten add and compare) as it pops it. A line's last byte and then its
// response pass a two-entry queue in front of the scanner, a summary register and
// an output register; the last two hold finished lines, so requests keep flowing
// while a response waits; req_ready drops only once all three are full. The csr
// port is always ready and must only be written while no line is in flight.
module scale_reading_parser_with_stability_unit #(
   parameter int TOKEN_MAX       = 31,
   parameter int FRACTION_DIGITS = 6,
   parameter int INTEGER_DIGITS  = 6
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [srp_pkg::BYTE_W-1:0]             req_data_byte,
   input  logic                                   req_end_of_line,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_found,
   output logic signed [srp_pkg::VALUE_W-1:0]     rsp_value_scaled,
   output logic                                   rsp_overflow,
   output logic                                   rsp_stable,
   output logic [srp_pkg::STREAK_W-1:0]           rsp_streak_length,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [srp_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [srp_pkg::BYTE_W-1:0]             csr_data
);

   localparam int MAG_W =
      $clog2(srp_pkg::pow10(5'(INTEGER_DIGITS + FRACTION_DIGITS)));

   logic [srp_pkg::BYTE_W-1:0]   separator_ff, separator_in;
   logic [srp_pkg::STREAK_W-1:0] stable_count_ff, stable_count_in;

   logic                    q_valid, q_pop;
   srp_pkg::byte_class_type q_entry;
   logic                    sum_valid, sum_take;
   srp_pkg::line_flags_type sum_flags;
   logic [MAG_W-1:0]        sum_mag;

   assign csr_ready = 1'b1;

   always_comb begin
      separator_in    = separator_ff;
      stable_count_in = stable_count_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            srp_pkg::CSR_SEPARATOR:    separator_in    = csr_data;
            srp_pkg::CSR_STABLE_COUNT: stable_count_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff    <= srp_pkg::SEPARATOR_RESET;
         stable_count_ff <= srp_pkg::STABLE_COUNT_RESET;
      end else begin
         separator_ff    <= separator_in;
         stable_count_ff <= stable_count_in;
      end
   end

   srp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_end_of_line (req_end_of_line),
      .separator       (separator_ff),
      .q_valid         (q_valid),
      .q_entry         (q_entry),
      .q_pop           (q_pop)
   );

   srp_scan #(
      .TOKEN_MAX       (TOKEN_MAX),
      .FRACTION_DIGITS (FRACTION_DIGITS),
      .INTEGER_DIGITS  (INTEGER_DIGITS),
      .MAG_W           (MAG_W)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .sum_valid (sum_valid),
      .sum_flags (sum_flags),
      .sum_mag   (sum_mag),
      .sum_take  (sum_take)
   );

   srp_result #(
      .MAG_W (MAG_W)
   ) u_result (
      .clock             (clock),
      .reset             (reset),
      .sum_valid         (sum_valid),
      .sum_flags         (sum_flags),
      .sum_mag           (sum_mag),
      .sum_take          (sum_take),
      .stable_count      (stable_count_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_value_scaled  (rsp_value_scaled),
      .rsp_overflow      (rsp_overflow),
      .rsp_stable        (rsp_stable),
      .rsp_streak_length (rsp_streak_length)
   );

endmodule

// ===== test/tb_scale_reading_parser_with_stability_unit.sv =====
`timescale 1ns / 1ps

typedef enum logic [1:0] {SCAN_SEEK, SCAN_TOKEN, SCAN_DONE} scan_phase_type;

typedef struct {
   logic                            found;
   logic [srp_pkg::VALUE_W-1:0]     value;
   logic                            overflow;
   logic                            stable;
   logic [srp_pkg::STREAK_W-1:0]    streak;
} reading_type;

class reading_scoreboard;
   localparam int TOKEN_LIMIT = 31;
   localparam int FRAC_DIGITS = 6;
   localparam int INT_DIGITS  = 6;

   logic [srp_pkg::BYTE_W-1:0]   separator;
   logic [srp_pkg::STREAK_W-1:0] needed_streak;
   scan_phase_type               phase;
   int unsigned                  tok_len;
   bit                           have_digit;
   bit                           have_sep;
   int unsigned                  frac_seen;
   longint unsigned              magnitude;
   bit                           saturated;
   bit                           line_minus;
   logic [srp_pkg::VALUE_W-1:0]  held;
   logic [srp_pkg::STREAK_W-1:0] streak;
   reading_type                  readings_due[$];
   int                           errors;

   function new();
      separator     = srp_pkg::SEPARATOR_RESET;
      needed_streak = srp_pkg::STABLE_COUNT_RESET;
      held          = '0;
      streak        = '0;
      errors        = 0;
      clear_line();
   endfunction

   function void clear_line();
      phase      = SCAN_SEEK;
      tok_len    = 0;
      have_digit = 0;
      have_sep   = 0;
      frac_seen  = 0;
      magnitude  = 0;
      saturated  = 0;
      line_minus = 0;
   endfunction

   function void write_register(logic [srp_pkg::CSR_INDEX_W-1:0] index,
                                logic [srp_pkg::BYTE_W-1:0] data);
      case (index)
         srp_pkg::CSR_SEPARATOR:    separator = data;
         srp_pkg::CSR_STABLE_COUNT: needed_streak = data;
         default: ;
      endcase
   endfunction

   function longint unsigned ten_to(int n);
      longint unsigned p;
      p = 1;
      repeat (n) p = p * 10;
      return p;
   endfunction

   function bit is_digit(logic [srp_pkg::BYTE_W-1:0] c);
      return c >= srp_pkg::CHAR_ZERO && c <= srp_pkg::CHAR_NINE;
   endfunction

   function bit starts_token(logic [srp_pkg::BYTE_W-1:0] c);
      return is_digit(c) || c == srp_pkg::CHAR_PLUS || c == srp_pkg::CHAR_MINUS
             || c == separator;
   endfunction

   function void add_digit(int unsigned d);
      longint unsigned ceiling;
      longint unsigned v;
      ceiling = ten_to(INT_DIGITS + FRAC_DIGITS) - 1;
      if (saturated) return;
      if (!have_sep) begin
         v = magnitude * 10 + longint'(d) * ten_to(FRAC_DIGITS);
         if (v > ceiling) begin
            magnitude = ceiling;
            saturated = 1;
         end else begin
            magnitude = v;
         end
      end else if (frac_seen < FRAC_DIGITS) begin
         magnitude = magnitude + longint'(d) * ten_to(FRAC_DIGITS - 1 - frac_seen);
         frac_seen++;
      end
   endfunction

   // Returns 0 when the byte cannot extend the open token.
   function bit append_byte(logic [srp_pkg::BYTE_W-1:0] c);
      if (is_digit(c)) begin
         have_digit = 1;
         add_digit(int'(c - srp_pkg::CHAR_ZERO));
      end else if (c == separator) begin
         if (have_sep) return 0;
         have_sep = 1;
      end else if (c == srp_pkg::CHAR_PLUS || c == srp_pkg::CHAR_MINUS) begin
         if (tok_len != 0) return 0;
      end else begin
         return 0;
      end
      tok_len++;
      return 1;
   endfunction

   function void close_token();
      if (have_digit) begin
         phase = SCAN_DONE;
      end else if (tok_len == 2) begin
         // A sign and a separator: keep going with the separator on its own.
         tok_len  = 1;
         have_sep = 1;
      end else begin
         phase = SCAN_SEEK;
      end
   endfunction

   function void feed_byte(logic [srp_pkg::BYTE_W-1:0] c);
      for (int pass = 0; pass < 3; pass++) begin
         if (phase == SCAN_DONE) return;
         if (phase == SCAN_SEEK) begin
            if (!starts_token(c)) return;
            phase      = SCAN_TOKEN;
            tok_len    = 0;
            have_digit = 0;
            have_sep   = 0;
            frac_seen  = 0;
            magnitude  = 0;
            saturated  = 0;
         end
         if (append_byte(c)) begin
            if (tok_len >= TOKEN_LIMIT) close_token();
            return;
         end
         close_token();
      end
   endfunction

   function void note_request(logic [srp_pkg::BYTE_W-1:0] c, logic eol);
      reading_type r;
      if (c == srp_pkg::CHAR_MINUS) line_minus = 1;
      feed_byte(c);
      if (!eol) return;
      if (phase == SCAN_TOKEN && have_digit) phase = SCAN_DONE;
      r.found    = (phase == SCAN_DONE);
      r.value    = '0;
      r.overflow = 0;
      r.stable   = 0;
      r.streak   = '0;
      if (r.found) begin
         r.value = magnitude[srp_pkg::VALUE_W-1:0];
         if (line_minus && r.value != 0) r.value = -r.value;
         if (streak == 0 || r.value == held) begin
            if (streak != srp_pkg::STREAK_MAX) streak++;
         end else begin
            streak = 1;
         end
         held       = r.value;
         r.streak   = streak;
         r.stable   = (streak >= needed_streak);
         r.overflow = saturated;
         if (r.stable) streak = '0;
      end else begin
         streak = '0;
      end
      readings_due.push_back(r);
      clear_line();
   endfunction

   function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endfunction

   function void check_response(reading_type got);
      reading_type want;
      if (readings_due.size() == 0) begin
         $error("response arrived with no line pending");
         errors++;
         return;
      end
      want = readings_due.pop_front();
      compare_field("found", 64'(want.found), 64'(got.found));
      compare_field("value_scaled", 64'(want.value), 64'(got.value));
      compare_field("overflow", 64'(want.overflow), 64'(got.overflow));
      compare_field("stable", 64'(want.stable), 64'(got.stable));
      compare_field("streak_length", 64'(want.streak), 64'(got.streak));
   endfunction
endclass

module tb_scale_reading_parser_with_stability_unit;

   localparam int CYCLE_LIMIT = 200000;
   localparam logic [srp_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 8'hFF;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_ready;
   logic [srp_pkg::BYTE_W-1:0]             req_data_byte = '0;
   logic                                   req_end_of_line = 1'b0;
   logic                                   rsp_valid;
   logic                                   rsp_ready = 1'b0;
   logic                                   rsp_found;
   logic signed [srp_pkg::VALUE_W-1:0]     rsp_value_scaled;
   logic                                   rsp_overflow;
   logic                                   rsp_stable;
   logic [srp_pkg::STREAK_W-1:0]           rsp_streak_length;
   logic                                   csr_valid = 1'b0;
   logic                                   csr_ready;
   logic [srp_pkg::CSR_INDEX_W-1:0]        csr_index = '0;
   logic [srp_pkg::BYTE_W-1:0]             csr_data = '0;

   int                           send_idle_pct = 11;
   int                           recv_idle_pct = 51;
   int                           bytes_sent;
   logic [srp_pkg::BYTE_W-1:0]   cur_sep = srp_pkg::SEPARATOR_RESET;
   logic [srp_pkg::BYTE_W-1:0]   line_bytes[$];
   logic [srp_pkg::BYTE_W-1:0]   last_line[$];
   reading_scoreboard            board = new();

   scale_reading_parser_with_stability_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_line   (req_end_of_line),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_value_scaled  (rsp_value_scaled),
      .rsp_overflow      (rsp_overflow),
      .rsp_stable        (rsp_stable),
      .rsp_streak_length (rsp_streak_length),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      reading_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.found    = rsp_found;
         got.value    = rsp_value_scaled;
         got.overflow = rsp_overflow;
         got.stable   = rsp_stable;
         got.streak   = rsp_streak_length;
         board.check_response(got);
      end
   end

   // Valid is only lowered when the sender decides to idle, so a back-to-back
   // request never sees valid dropped and raised in the same step.
   task automatic send_byte(input logic [srp_pkg::BYTE_W-1:0] b, input logic eol);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= b;
      req_end_of_line <= eol;
      do @(posedge clock); while (!req_ready);
      board.note_request(b, eol);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(8'(s[i]), i == s.len() - 1);
   endtask

   task automatic send_line();
      foreach (line_bytes[i]) send_byte(line_bytes[i], i == line_bytes.size() - 1);
      bytes_sent += line_bytes.size();
   endtask

   task automatic write_csr(input logic [srp_pkg::CSR_INDEX_W-1:0] index,
                            input logic [srp_pkg::BYTE_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_register(index, data);
      if (index == srp_pkg::CSR_SEPARATOR) cur_sep = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.readings_due.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   function automatic logic [srp_pkg::BYTE_W-1:0] rand_digit();
      return 8'(srp_pkg::CHAR_ZERO + 8'($urandom_range(9)));
   endfunction

   function automatic logic [srp_pkg::BYTE_W-1:0] rand_letter();
      return ($urandom_range(3) == 0) ? 8'h20 : 8'($urandom_range(65, 90));
   endfunction

   // Mostly readings as a scale sends them, with repeats to build streaks, plus short
   // mixes of signs, separators, periods, letters and digits, and raw noise.
   function automatic void build_line();
      int kind;
      int n;
      kind = $urandom_range(99);
      line_bytes.delete();
      if (kind < 30 && last_line.size() != 0) begin
         line_bytes = last_line;
         return;
      end
      if (kind < 75) begin
         repeat ($urandom_range(3)) line_bytes.push_back(rand_letter());
         if ($urandom_range(9) < 4)
            line_bytes.push_back($urandom_range(1) ? srp_pkg::CHAR_MINUS
                                                   : srp_pkg::CHAR_PLUS);
         n = ($urandom_range(19) == 0) ? $urandom_range(8, 35) : $urandom_range(7);
         repeat (n) line_bytes.push_back(rand_digit());
         if ($urandom_range(1)) begin
            line_bytes.push_back(cur_sep);
            repeat ($urandom_range(8)) line_bytes.push_back(rand_digit());
         end
         repeat ($urandom_range(2)) line_bytes.push_back(rand_letter());
         if ($urandom_range(9) == 0) line_bytes.push_back(srp_pkg::CHAR_MINUS);
      end else if (kind < 88) begin
         repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(6))
               0: line_bytes.push_back(srp_pkg::CHAR_PLUS);
               1: line_bytes.push_back(srp_pkg::CHAR_MINUS);
               2: line_bytes.push_back(cur_sep);
               3: line_bytes.push_back(srp_pkg::CHAR_PERIOD);
               4: line_bytes.push_back(rand_letter());
               default: line_bytes.push_back(rand_digit());
            endcase
         end
      end else begin
         repeat ($urandom_range(1, 6)) line_bytes.push_back(8'($urandom_range(255)));
      end
      if (line_bytes.size() == 0) line_bytes.push_back(rand_letter());
      last_line = line_bytes;
   endfunction

   task automatic random_lines(input int byte_goal);
      bytes_sent = 0;
      while (bytes_sent < byte_goal) begin
         build_line();
         send_line();
      end
   endtask

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_scale_reading_parser_with_stability_unit NOT OK");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: sign and fraction, no number, saturation, a sign
      // followed by a separator and a letter, truncated fraction, minus zero,
      // and a minus after the number.
      send_text("-1.5");
      send_byte(8'hFF, 1'b1);
      send_text("9999999");
      send_text("-.a5");
      send_text("0.1234567");
      send_text("-0");
      send_text("7-");
      send_byte(8'h00, 1'b1);
      drain();

      write_csr(srp_pkg::CSR_SEPARATOR, 8'h2C);
      write_csr(srp_pkg::CSR_STABLE_COUNT, 8'd3);
      random_lines(200);
      drain();

      send_idle_pct = 51;
      recv_idle_pct = 11;
      write_csr(srp_pkg::CSR_SEPARATOR, srp_pkg::CHAR_MINUS);
      write_csr(srp_pkg::CSR_STABLE_COUNT, 8'hFF);
      random_lines(100);
      // A long run of equal readings to reach the largest stable count.
      repeat (256) send_text("7");
      drain();

      write_csr(srp_pkg::CSR_SEPARATOR, 8'hFF);
      write_csr(srp_pkg::CSR_STABLE_COUNT, 8'd2);
      write_csr(CSR_UNUSED, 8'hA5);
      random_lines(150);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(srp_pkg::CSR_SEPARATOR, 8'h35);
      write_csr(srp_pkg::CSR_STABLE_COUNT, 8'd0);
      random_lines(150);
      drain();

      write_csr(srp_pkg::CSR_SEPARATOR, 8'h00);
      write_csr(srp_pkg::CSR_STABLE_COUNT, 8'd1);
      random_lines(100);
      drain();

      repeat (10) @(posedge clock);
      if (board.errors == 0 && board.readings_due.size() == 0) begin
         $display("tb_scale_reading_parser_with_stability_unit OK");
      end else begin
         $display("tb_scale_reading_parser_with_stability_unit NOT OK");
      end
      $finish;
   end
endmodule
